/* rtl/bfth_pkg.sv */
// Shared constants and types for the three-hash Bloom filter.
`default_nettype none

package bfth_pkg;

  // Default store size: 2**17 bytes.
  localparam int STORE_BYTE_BITS_DEF = 17;

  // Hash multipliers.
  localparam logic [31:0] HASH_MUL_A = 32'd2654435761;
  localparam logic [31:0] HASH_MUL_B = 32'd2246822519;

  // Key and hash widths, bit select within a byte.
  localparam int KEY_W     = 32;
  localparam int BIT_SEL_W = 3;
  localparam int NUM_HASH  = 3;

  // Configuration register.
  localparam int          CFG_W     = 5;
  localparam logic [4:0]  CFG_RESET = 5'd17;

  // Operation codes; the fourth code is ignored.
  localparam logic [1:0] OP_INSERT = 2'd0;
  localparam logic [1:0] OP_TEST   = 2'd1;
  localparam logic [1:0] OP_CLEAR  = 2'd2;

  // Three hash words of one key.
  typedef logic [NUM_HASH-1:0][KEY_W-1:0] hash_set_t;

  // Control sequencer states.
  typedef enum logic [1:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_ACCESS,
    ST_DONE
  } state_t;

endpackage

`default_nettype wire

/* rtl/bfth_hash.sv */
// Registered hash stage: the key and its two multiplicative hashes.
`default_nettype none

module bfth_hash (
  input  wire logic              clk,
  input  wire logic              load,
  input  wire logic [31:0]       key,
  output bfth_pkg::hash_set_t    hashes
);
  import bfth_pkg::*;

  hash_set_t hashes_r;
  hash_set_t hashes_nxt;

  // Products are taken modulo 2**32.
  always_comb begin
    hashes_nxt[0] = key;
    hashes_nxt[1] = KEY_W'(key * HASH_MUL_A);
    hashes_nxt[2] = KEY_W'(key * HASH_MUL_B);
  end

  // Capture the hashes when a request is taken.
  always_ff @(posedge clk) begin
    if (load) begin
      hashes_r <= hashes_nxt;
    end
  end

  assign hashes = hashes_r;

endmodule

`default_nettype wire

/* rtl/bloom_filter_three_hash_core.sv */
// Top level of the three-hash Bloom filter with its byte-wide bit store.
//
//   Channel  Direction  Handshake               Payload
//   in_      input      in_valid / in_ready     in_operation, in_key
//   out_     output     out_valid / out_ready   out_present
//   cfg_     input      cfg_wr_en               cfg_byte_addr_bits
//
// Insert and test read the three hashed bytes one by one through the single
// read port of the store, with each write-back but the last overlapping the next
// read; a test then hands its result on when the output register is free.
// Clear zeroes the whole store, one byte written per cycle. After reset the same
// sweep zeroes the store before the first request is taken. A stalled output
// holds a test result in the output register while the next request is already
// accepted.
`default_nettype none

module bloom_filter_three_hash_core #(
  parameter int STORE_BYTE_BITS = bfth_pkg::STORE_BYTE_BITS_DEF
) (
  input  wire logic                        clk,
  input  wire logic                        rst_n,
  input  wire logic                        in_valid,
  output      logic                        in_ready,
  input  wire logic [1:0]                  in_operation,
  input  wire logic [bfth_pkg::KEY_W-1:0]  in_key,
  output      logic                        out_valid,
  input  wire logic                        out_ready,
  output      logic                        out_present,
  input  wire logic                        cfg_wr_en,
  input  wire logic [bfth_pkg::CFG_W-1:0]  cfg_byte_addr_bits
);
  import bfth_pkg::*;

  localparam int Depth = 1 << STORE_BYTE_BITS;
  localparam int AddrW = STORE_BYTE_BITS;

  state_t               state_r, state_nxt;
  logic [1:0]           cnt_r, cnt_nxt;
  logic [AddrW-1:0]     clr_ptr_r, clr_ptr_nxt;
  logic [1:0]           op_r, op_nxt;
  logic                 pres_r, pres_nxt;
  logic                 out_valid_r, out_valid_nxt;
  logic                 out_present_r, out_present_nxt;
  logic [CFG_W-1:0]     cfg_bits_r;
  logic [AddrW-1:0]     addr_r, addr_nxt;
  logic [BIT_SEL_W-1:0] bsel_r, bsel_nxt;

  logic [7:0]           mem [Depth];
  logic [7:0]           rd_data_r;
  logic                 fwd_r;
  logic [7:0]           fwd_data_r;

  logic                 mem_we, mem_re;
  logic [AddrW-1:0]     mem_wa, mem_ra;
  logic [7:0]           mem_wd;

  logic                 accept;
  hash_set_t            hashes;
  logic [KEY_W-1:0]     hsel;
  logic [AddrW-1:0]     byte_mask;
  logic [7:0]           eff_data;
  logic [7:0]           set_byte;
  logic                 bit_hit;

  assign accept = in_valid && in_ready;

  bfth_hash u_hash (
    .clk    (clk),
    .load   (accept),
    .key    (in_key),
    .hashes (hashes)
  );

  // Byte mask; a width above the store size saturates to the full store.
  always_comb begin
    for (int i = 0; i < AddrW; i++) begin
      byte_mask[i] = (i < int'(cfg_bits_r));
    end
  end

  // Configuration register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_bits_r <= CFG_RESET;
    end else if (cfg_wr_en) begin
      cfg_bits_r <= cfg_byte_addr_bits;
    end
  end

  // Hash word for the read in the current access step.
  always_comb begin
    unique case (cnt_r)
      2'd0:    hsel = hashes[0];
      2'd1:    hsel = hashes[1];
      2'd2:    hsel = hashes[2];
      default: hsel = hashes[0];
    endcase
  end

  assign mem_ra = hsel[AddrW+BIT_SEL_W-1:BIT_SEL_W] & byte_mask;

  // Read data, with the byte written in the cycle of the read forwarded.
  assign eff_data = fwd_r ? fwd_data_r : rd_data_r;
  assign set_byte = eff_data | (8'd1 << bsel_r);
  assign bit_hit  = eff_data[bsel_r];

  // Sequencer: clear sweep, request intake, read-modify-write steps, result.
  always_comb begin
    state_nxt       = state_r;
    cnt_nxt         = cnt_r;
    clr_ptr_nxt     = clr_ptr_r;
    op_nxt          = op_r;
    pres_nxt        = pres_r;
    addr_nxt        = addr_r;
    bsel_nxt        = bsel_r;
    out_valid_nxt   = out_valid_r && !out_ready;
    out_present_nxt = out_present_r;
    in_ready        = 1'b0;
    mem_we          = 1'b0;
    mem_re          = 1'b0;
    mem_wa          = addr_r;
    mem_wd          = set_byte;

    unique case (state_r)
      ST_CLEAR: begin
        mem_we      = 1'b1;
        mem_wa      = clr_ptr_r;
        mem_wd      = 8'd0;
        clr_ptr_nxt = clr_ptr_r + 1'b1;
        if (clr_ptr_r == {AddrW{1'b1}}) begin
          state_nxt = ST_IDLE;
        end
      end

      ST_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          op_nxt = in_operation;
          cnt_nxt = 2'd0;
          if (in_operation == OP_INSERT || in_operation == OP_TEST) begin
            state_nxt = ST_ACCESS;
          end else if (in_operation == OP_CLEAR) begin
            state_nxt = ST_CLEAR;
          end
        end
      end

      ST_ACCESS: begin
        // Read the next hashed byte.
        if (cnt_r != 2'd3) begin
          mem_re   = 1'b1;
          addr_nxt = mem_ra;
          bsel_nxt = hsel[BIT_SEL_W-1:0];
        end
        // Check or set the bit of the byte read in the previous step.
        if (cnt_r == 2'd0) begin
          pres_nxt = 1'b1;
        end else begin
          pres_nxt = pres_r & bit_hit;
          mem_we   = (op_r == OP_INSERT);
        end
        cnt_nxt = cnt_r + 2'd1;
        if (cnt_r == 2'd3) begin
          cnt_nxt   = 2'd0;
          state_nxt = (op_r == OP_TEST) ? ST_DONE : ST_IDLE;
        end
      end

      ST_DONE: begin
        if (!out_valid_r || out_ready) begin
          out_valid_nxt   = 1'b1;
          out_present_nxt = pres_r;
          state_nxt       = ST_IDLE;
        end
      end

      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  // Control registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_CLEAR;
      cnt_r       <= 2'd0;
      clr_ptr_r   <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      cnt_r       <= cnt_nxt;
      clr_ptr_r   <= clr_ptr_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // Payload registers.
  always_ff @(posedge clk) begin
    op_r          <= op_nxt;
    pres_r        <= pres_nxt;
    addr_r        <= addr_nxt;
    bsel_r        <= bsel_nxt;
    out_present_r <= out_present_nxt;
  end

  // Bit store: one write port, one read port, registered read data.
  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[mem_wa] <= mem_wd;
    end
    if (mem_re) begin
      rd_data_r <= mem[mem_ra];
    end
  end

  // Forward a byte written to the same address as the read in that cycle.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fwd_r <= 1'b0;
    end else begin
      fwd_r <= mem_we && mem_re && (mem_wa == mem_ra);
    end
  end

  always_ff @(posedge clk) begin
    fwd_data_r <= mem_wd;
  end

  assign out_valid   = out_valid_r;
  assign out_present = out_present_r;

  // No request is taken during the clear sweep.
  a_no_accept_in_clear: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_CLEAR) |-> !in_ready)
    else $error("request taken during clear sweep");

  // A new result appears only after a test has finished its accesses.
  a_result_after_test: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid) |-> $past(state_r == ST_DONE))
    else $error("result without a finished test");

  // A test never writes the store.
  a_test_no_write: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_ACCESS && op_r == OP_TEST) |-> !mem_we)
    else $error("store written during a test");

  // Forwarding only follows a write and a read of the same byte.
  a_fwd_source: assert property (@(posedge clk) disable iff (!rst_n)
    fwd_r |-> $past(state_r == ST_ACCESS && op_r == OP_INSERT))
    else $error("forwarding outside an insert");

endmodule

`default_nettype wire

/* test/tb_top.sv */
// Testbench for the three-hash Bloom filter core, checked against a behavioral predictor.
`timescale 1ns / 100ps

module tb_top;
  import bfth_pkg::*;

  localparam int STORE_BITS = STORE_BYTE_BITS_DEF;
  localparam int STORE_DEPTH = 1 << STORE_BITS;
  localparam logic [1:0] OP_UNUSED = 2'd3;
  // A clear or the reset sweep keeps both channels quiet for its whole sweep of the store.
  localparam int WATCHDOG_LIMIT = 3 * STORE_DEPTH;
  localparam int SETTLE_CYCLES = 16;
  localparam int CHUNK_ITEMS = 200;

  logic              clk = 1'b0;
  logic              rst_n;
  logic              in_valid;
  logic              in_ready;
  logic [1:0]        in_operation;
  logic [KEY_W-1:0]  in_key;
  logic              out_valid;
  logic              out_ready;
  logic              out_present;
  logic              cfg_wr_en;
  logic [CFG_W-1:0]  cfg_byte_addr_bits;

  // Predictor state: the filter bytes and the address width in use.
  logic [7:0]        filter_bytes [STORE_DEPTH];
  logic [CFG_W-1:0]  width_setting;
  logic              pending_present [$];

  int mismatch_count = 0;
  int idle_cycles = 0;
  int send_idle_pct = 0;
  int recv_stall_pct = 0;

  bloom_filter_three_hash_core u_top (
    .clk                (clk),
    .rst_n              (rst_n),
    .in_valid           (in_valid),
    .in_ready           (in_ready),
    .in_operation       (in_operation),
    .in_key             (in_key),
    .out_valid          (out_valid),
    .out_ready          (out_ready),
    .out_present        (out_present),
    .cfg_wr_en          (cfg_wr_en),
    .cfg_byte_addr_bits (cfg_byte_addr_bits)
  );

  // Clock with a 10 ns period.
  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // The receiver stalls at random according to the current phase.
  always @(negedge clk) begin
    out_ready <= ($urandom_range(99) >= recv_stall_pct);
  end

  // Byte address mask for a width setting; widths above the store saturate.
  function automatic logic [STORE_BITS-1:0] address_mask(input logic [CFG_W-1:0] w);
    int eff;
    eff = (w > STORE_BITS) ? STORE_BITS : int'(w);
    return STORE_BITS'((32'd1 << eff) - 32'd1);
  endfunction

  // Apply one accepted request to the predictor and queue any expected result.
  task automatic predict_request(input logic [1:0] op, input logic [KEY_W-1:0] key);
    logic [KEY_W-1:0]      hw [NUM_HASH];
    logic [STORE_BITS-1:0] mask;
    logic [STORE_BITS-1:0] addr;
    logic                  hit;
    hw[0] = key;
    hw[1] = key * HASH_MUL_A;
    hw[2] = key * HASH_MUL_B;
    mask = address_mask(width_setting);
    hit = 1'b1;
    case (op)
      OP_CLEAR: begin
        foreach (filter_bytes[i]) filter_bytes[i] = 8'h00;
      end
      OP_INSERT: begin
        for (int i = 0; i < NUM_HASH; i++) begin
          addr = STORE_BITS'(hw[i] >> BIT_SEL_W) & mask;
          filter_bytes[addr][hw[i][BIT_SEL_W-1:0]] = 1'b1;
        end
      end
      OP_TEST: begin
        for (int i = 0; i < NUM_HASH; i++) begin
          addr = STORE_BITS'(hw[i] >> BIT_SEL_W) & mask;
          if (!filter_bytes[addr][hw[i][BIT_SEL_W-1:0]]) hit = 1'b0;
        end
        pending_present.push_back(hit);
      end
      default: begin
        // The fourth operation code leaves everything unchanged.
      end
    endcase
  endtask

  // Send one request; called and returning at a falling edge with valid left high.
  task automatic send_request(input logic [1:0] op, input logic [KEY_W-1:0] key);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_valid <= 1'b1;
    in_operation <= op;
    in_key <= key;
    do @(posedge clk); while (!in_ready);
    predict_request(op, key);
    @(negedge clk);
  endtask

  // Close with a test request, wait for every result, then let the block go idle.
  task automatic settle_block();
    send_request(OP_TEST, $urandom());
    in_valid <= 1'b0;
    while (pending_present.size() != 0) @(negedge clk);
    repeat (SETTLE_CYCLES) @(negedge clk);
  endtask

  // Write the address width register; only called while the block is idle.
  task automatic write_width(input logic [CFG_W-1:0] value);
    cfg_wr_en <= 1'b1;
    cfg_byte_addr_bits <= value;
    @(negedge clk);
    cfg_wr_en <= 1'b0;
    width_setting = value;
  endtask

  task automatic note_mismatch(input string what, input logic exp_v, input logic got_v);
    mismatch_count++;
    if (mismatch_count <= 10) begin
      $display("Mismatch at %0t: %s, present expected %b actual %b",
               $realtime, what, exp_v, got_v);
    end
  endtask

  // Check each accepted result against the oldest expectation.
  always @(posedge clk) begin
    if (rst_n && out_valid && out_ready) begin
      if (pending_present.size() == 0) begin
        note_mismatch("result with nothing pending", 1'bx, out_present);
      end else if (out_present !== pending_present[0]) begin
        note_mismatch("wrong present flag", pending_present[0], out_present);
        void'(pending_present.pop_front());
      end else begin
        void'(pending_present.pop_front());
      end
    end
  end

  // Watchdog on cycles in which neither channel moves a request or result.
  always @(posedge clk) begin
    if (!rst_n || (in_valid && in_ready) || (out_valid && out_ready)) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= WATCHDOG_LIMIT) begin
        $display("Regression FAIL");
        $finish;
      end
    end
  end

  // Extreme keys, every operation, the ignored code and a clear at the reset width.
  task automatic test_directed_ops();
    send_request(OP_TEST, 32'h0000_0000);
    send_request(OP_INSERT, 32'h0000_0000);
    send_request(OP_TEST, 32'h0000_0000);
    send_request(OP_TEST, 32'hFFFF_FFFF);
    send_request(OP_INSERT, 32'hFFFF_FFFF);
    send_request(OP_TEST, 32'hFFFF_FFFF);
    send_request(OP_UNUSED, 32'h1234_5678);
    send_request(OP_TEST, 32'h1234_5678);
    send_request(OP_INSERT, 32'h8000_0001);
    send_request(OP_TEST, 32'h8000_0001);
    send_request(OP_CLEAR, 32'hFFFF_FFFF);
    send_request(OP_TEST, 32'h0000_0000);
    send_request(OP_TEST, 32'hFFFF_FFFF);
    send_request(OP_INSERT, 32'hA5A5_A5A5);
    send_request(OP_TEST, 32'h5A5A_5A5A);
    settle_block();
  endtask

  // Narrowest width, saturating widths and a one-bit width.
  task automatic test_addr_width();
    write_width(5'd0);
    send_request(OP_INSERT, 32'h0000_0001);
    send_request(OP_TEST, 32'h0000_0001);
    send_request(OP_TEST, 32'hFFFF_FFF8);
    send_request(OP_INSERT, 32'h0000_0007);
    send_request(OP_TEST, 32'h0000_0000);
    settle_block();
    write_width(5'd31);
    send_request(OP_TEST, 32'h0000_0001);
    send_request(OP_INSERT, 32'hDEAD_BEEF);
    send_request(OP_TEST, 32'hDEAD_BEEF);
    settle_block();
    write_width(5'd18);
    send_request(OP_TEST, 32'hDEAD_BEEF);
    settle_block();
    write_width(5'd1);
    send_request(OP_INSERT, 32'h0000_0008);
    send_request(OP_TEST, 32'h0000_0010);
    settle_block();
  endtask

  // Random inserts and tests, the tests mostly of keys already inserted, with some noise.
  task automatic run_random_chunk(input int n_items, input bit with_clear);
    logic [KEY_W-1:0] known_keys [$];
    logic [KEY_W-1:0] key;
    int clear_at;
    int r;
    clear_at = with_clear ? $urandom_range(n_items - 1, n_items / 4) : -1;
    for (int i = 0; i < n_items; i++) begin
      r = $urandom_range(99);
      if (i == clear_at) begin
        send_request(OP_CLEAR, $urandom());
        known_keys.delete();
      end else if (r < 35) begin
        if (r < 10 && known_keys.size() > 0) begin
          key = known_keys[$urandom_range(known_keys.size() - 1)] ^ (32'd1 << $urandom_range(31));
        end else begin
          key = $urandom();
        end
        send_request(OP_INSERT, key);
        if (known_keys.size() < 64) known_keys.push_back(key);
        else known_keys[$urandom_range(63)] = key;
      end else if (r < 75) begin
        if (known_keys.size() > 0) key = known_keys[$urandom_range(known_keys.size() - 1)];
        else key = $urandom();
        send_request(OP_TEST, key);
      end else if (r < 93) begin
        if (r < 84 && known_keys.size() > 0) begin
          key = known_keys[$urandom_range(known_keys.size() - 1)] ^ (32'd1 << $urandom_range(31));
        end else begin
          key = $urandom();
        end
        send_request(OP_TEST, key);
      end else if (r < 97) begin
        send_request(OP_UNUSED, $urandom());
      end else begin
        case ($urandom_range(3))
          0: key = 32'h0000_0000;
          1: key = 32'hFFFF_FFFF;
          2: key = 32'h8000_0000;
          default: key = 32'h0000_0001;
        endcase
        send_request(r[0] ? OP_TEST : OP_INSERT, key);
      end
    end
  endtask

  // One idling phase with two width settings.
  task automatic test_random_traffic(input int send_pct, input int stall_pct,
                                     input logic [CFG_W-1:0] width_a,
                                     input logic [CFG_W-1:0] width_b,
                                     input bit with_clear);
    send_idle_pct = send_pct;
    recv_stall_pct = stall_pct;
    write_width(width_a);
    run_random_chunk(CHUNK_ITEMS, with_clear);
    settle_block();
    write_width(width_b);
    run_random_chunk(CHUNK_ITEMS, 1'b0);
    settle_block();
  endtask

  // Reset, the test sequence and the final verdict.
  initial begin
    rst_n = 1'b0;
    in_valid = 1'b0;
    in_operation = OP_INSERT;
    in_key = '0;
    out_ready = 1'b0;
    cfg_wr_en = 1'b0;
    cfg_byte_addr_bits = CFG_RESET;
    width_setting = CFG_RESET;
    foreach (filter_bytes[i]) filter_bytes[i] = 8'h00;
    repeat (11) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    test_directed_ops();
    test_addr_width();
    test_random_traffic(0, 0, 5'd17, 5'd4, 1'b1);
    test_random_traffic(47, 0, 5'd0, 5'd12, 1'b0);
    test_random_traffic(0, 47, 5'd31, CFG_W'($urandom_range(31)), 1'b1);
    test_random_traffic(10, 10, 5'd2, 5'd18, 1'b0);

    if (mismatch_count == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule
